// ===== rtl/fsv_pkg.sv =====
// Package for the field serializer: operation codes, shifter modes and the
// structs between the top level and the byte shifter. It has no dependencies.
package fsv_pkg;

  // Operation codes on the input channel.
  typedef enum logic [3:0] {
    OP_U8     = 4'd0,
    OP_U16LE  = 4'd1,
    OP_U32LE  = 4'd2,
    OP_U64LE  = 4'd3,
    OP_U16BE  = 4'd4,
    OP_U32BE  = 4'd5,
    OP_U64BE  = 4'd6,
    OP_VARINT = 4'd7,
    OP_ZIGZAG = 4'd8
  } op_e;

  // Ways the shifter walks its word.
  typedef enum logic [1:0] {
    MODE_LE,
    MODE_BE,
    MODE_VARINT
  } mode_e;

  // Shifter control states.
  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_e;

  localparam int unsigned WordW  = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 7;
  localparam int unsigned CountW = 4;

  // Load command from the top level to the shifter.
  typedef struct packed {
    logic              load;
    mode_e             mode;
    logic [CountW-1:0] nbytes;
    logic [WordW-1:0]  data;
  } load_t;

  // Shifter status back to the top level.
  typedef struct packed {
    logic busy;
    logic last;
  } status_t;

endpackage

// ===== rtl/fsv_shift.sv =====
// Byte shifter of the field serializer: holds one value and hands out one
// encoded byte per advance. Depends on fsv_pkg.
module fsv_shift (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsv_pkg::load_t                load_i,
  input  logic                          advance_i,
  output logic [fsv_pkg::ByteW-1:0]     byte_o,
  output fsv_pkg::status_t              stat_o
);

  fsv_pkg::state_e                  state_q, state_d;
  fsv_pkg::mode_e                   mode_q;
  logic [fsv_pkg::WordW-1:0]        sh_q;
  logic [fsv_pkg::CountW-1:0]       cnt_q;
  logic                             last;

  // The current byte is the final one of the value.
  always_comb begin
    unique case (mode_q)
      fsv_pkg::MODE_VARINT: last = (sh_q[fsv_pkg::WordW-1:fsv_pkg::GroupW] == '0);
      default:              last = (cnt_q == fsv_pkg::CountW'(1));
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsv_pkg::ST_IDLE:  if (load_i.load) state_d = fsv_pkg::ST_SHIFT;
      fsv_pkg::ST_SHIFT: if (advance_i && last) state_d = fsv_pkg::ST_IDLE;
      default:           state_d = fsv_pkg::ST_IDLE;
    endcase
  end

  // Outputs: the byte at the emitting end of the word and the status.
  always_comb begin
    unique case (mode_q)
      fsv_pkg::MODE_LE:     byte_o = sh_q[fsv_pkg::ByteW-1:0];
      fsv_pkg::MODE_BE:     byte_o = sh_q[fsv_pkg::WordW-1:fsv_pkg::WordW-fsv_pkg::ByteW];
      fsv_pkg::MODE_VARINT: byte_o = {~last, sh_q[fsv_pkg::GroupW-1:0]};
      default:              byte_o = '0;
    endcase
    stat_o.busy = (state_q == fsv_pkg::ST_SHIFT);
    stat_o.last = last;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Word, mode and byte count: loaded on a new value, shifted on each advance.
  always_ff @(posedge clk_i) begin
    if (load_i.load && state_q == fsv_pkg::ST_IDLE) begin
      sh_q   <= load_i.data;
      mode_q <= load_i.mode;
      cnt_q  <= load_i.nbytes;
    end else if (advance_i && state_q == fsv_pkg::ST_SHIFT) begin
      unique case (mode_q)
        fsv_pkg::MODE_LE:     sh_q <= sh_q >> fsv_pkg::ByteW;
        fsv_pkg::MODE_BE:     sh_q <= sh_q << fsv_pkg::ByteW;
        fsv_pkg::MODE_VARINT: sh_q <= sh_q >> fsv_pkg::GroupW;
        default:              sh_q <= sh_q;
      endcase
      cnt_q <= cnt_q - fsv_pkg::CountW'(1);
    end
  end

endmodule

// ===== rtl/field_serializer_varint.sv =====
// Field serializer top level: operation decode, input handshake and output
// register. Depends on fsv_pkg and fsv_shift.
//
// Usage: each input transaction carries a 64-bit value and an operation code
// (u8, u16/u32/u64 in little- or big-endian order, LEB128 varint, zigzag
// varint). The block returns the encoding as a run of output transactions, one
// byte each, with last_o set on the final byte. Unused operation codes are
// accepted and give no output.
// Start: out_valid_o rises once the accepted value is loaded into the shifter
// and its first byte has moved into the output register.
// Throughput: the byte shifter emits one byte per cycle while the output
// register is free. One value is in the shifter at a time; in_stall_o is high
// while it is busy, so a new value is taken only after the final byte of the
// last one has left the shifter.
// Stall: while out_stall_i holds, the output register keeps its byte and the
// shifter waits; the next byte follows in the cycle after it is taken.
// Reset: rst_ni clears the shifter state and the output valid; any value in
// flight is dropped.
module field_serializer_varint (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  fsv_pkg::load_t              load;
  fsv_pkg::status_t            stat;
  logic [fsv_pkg::ByteW-1:0]   sh_byte;
  logic                        in_accept;
  logic                        op_ok;
  logic                        advance;
  logic                        out_valid_q;
  logic [fsv_pkg::ByteW-1:0]   out_byte_q;
  logic                        last_q;

  assign in_stall_o = stat.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Decode the operation into a shifter mode, byte count and start word.
  always_comb begin
    op_ok       = 1'b1;
    load.mode   = fsv_pkg::MODE_LE;
    load.nbytes = '0;
    load.data   = value_i;
    unique case (fsv_pkg::op_e'(operation_i))
      fsv_pkg::OP_U8:    load.nbytes = fsv_pkg::CountW'(1);
      fsv_pkg::OP_U16LE: load.nbytes = fsv_pkg::CountW'(2);
      fsv_pkg::OP_U32LE: load.nbytes = fsv_pkg::CountW'(4);
      fsv_pkg::OP_U64LE: load.nbytes = fsv_pkg::CountW'(8);
      fsv_pkg::OP_U16BE: begin
        load.mode   = fsv_pkg::MODE_BE;
        load.nbytes = fsv_pkg::CountW'(2);
        load.data   = value_i << 48;
      end
      fsv_pkg::OP_U32BE: begin
        load.mode   = fsv_pkg::MODE_BE;
        load.nbytes = fsv_pkg::CountW'(4);
        load.data   = value_i << 32;
      end
      fsv_pkg::OP_U64BE: begin
        load.mode   = fsv_pkg::MODE_BE;
        load.nbytes = fsv_pkg::CountW'(8);
      end
      fsv_pkg::OP_VARINT: load.mode = fsv_pkg::MODE_VARINT;
      fsv_pkg::OP_ZIGZAG: begin
        // Zigzag: shift left by one and flip every bit for negative values.
        load.mode = fsv_pkg::MODE_VARINT;
        load.data = (value_i << 1) ^ {fsv_pkg::WordW{value_i[fsv_pkg::WordW-1]}};
      end
      default: op_ok = 1'b0;
    endcase
    load.load = in_accept && op_ok;
  end

  // Move a byte out of the shifter whenever the output register is free.
  assign advance = stat.busy && (!out_valid_q || !out_stall_i);

  fsv_shift u_shift (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .advance_i (advance),
    .byte_o    (sh_byte),
    .stat_o    (stat)
  );

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= sh_byte;
      last_q     <= stat.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // A valid operation occupies the shifter in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op_ok) |=> in_stall_o)
    else $error("shifter not busy after a load");

  // A byte that is not the final one is followed at once by the next byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap inside an encoded value");

  // The shifter goes idle only after handing over the final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> (out_valid_o && last_o))
    else $error("shifter went idle without a final byte");

endmodule
